### hw/rtl/cwkd_pkg.sv
// Shared constants, payload structs and sequencer states for the
// exactly-k-distinct window counter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cwkd_pkg;

	localparam int VALUE_COUNT = 256;
	localparam int MAX_LEN     = 1024;

	localparam int VALUE_W = 8;
	localparam int SLOT_W  = $clog2(VALUE_COUNT);
	localparam int POS_W   = $clog2(MAX_LEN + 1);
	localparam int HADDR_W = $clog2(MAX_LEN);
	localparam int TALLY_W = POS_W;
	localparam int DIST_W  = 9;
	localparam int TOTAL_W = 20;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// request queue between front and back
	localparam int FQ_DEPTH = 4;
	localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
	localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

	// result queue
	localparam int RQ_DEPTH = 2;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	// configuration port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_DISTINCT_TARGET = 1'b0;
	localparam logic [DIST_W-1:0]    DIST_TARGET_RESET   = 9'd1;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
		logic               skip;   // sequence already full, not stored
	} front_item_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] running_count;
		logic               last_res;
		logic               overflow;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_HEAD,
		ST_EVDEC,
		ST_FETCH,
		ST_CHK,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

### hw/rtl/count_windows_with_k_distinct.sv
// Top level of the exactly-k-distinct window counter: configuration
// register, front end, back end and result queue. Depends on cwkd_pkg.
//
// Usage:
//   Requests (value, last) enter while full is low; push with full low
//   takes one. Each request gives one result (running_count, last_res,
//   overflow) in request order; it is on the result ports while empty is
//   low and pop with empty low takes it.
//   distinct_target is written over the APB port at byte address 0 while
//   the block is idle; reads return it.
//   A stored request passes through the back end states in order (start,
//   tally increment, head fetch, check or evict, finish), with a further
//   fetch and table check for each repeated head entry stripped and one
//   after an eviction that leaves older entries in the window. The back
//   end works on one request at a time and starts the next only after
//   finishing the last. A request beyond the length limit goes from start
//   straight to finish.
//   Reset clears all sequence state at once through the table valid bits;
//   no clearing pass is needed. The result of a last request ends the
//   sequence and clears the state the same way.
//   Stalls: two results queue up, then the back end holds, the 4-entry
//   request queue fills and full rises.
`timescale 1ns / 1ps
`default_nettype none

module count_windows_with_k_distinct (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [cwkd_pkg::VALUE_W-1:0]  value,
	input  wire logic                          last,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [cwkd_pkg::TOTAL_W-1:0]       running_count,
	output logic                               last_res,
	output logic                               overflow,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cwkd_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [cwkd_pkg::PDATA_W-1:0]  pwdata,
	output logic [cwkd_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready
);

	logic [cwkd_pkg::DIST_W-1:0]    target_q;
	logic [cwkd_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           reg_wr;
	logic                           fe_valid, fe_pop;
	cwkd_pkg::front_item_t          fe_item;
	logic                           res_space, res_push;
	cwkd_pkg::result_t              res_out, res_head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[cwkd_pkg::PADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			cwkd_pkg::REG_DISTINCT_TARGET: prdata = cwkd_pkg::PDATA_W'(target_q);
			default:                       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= cwkd_pkg::DIST_TARGET_RESET;
		end else if (reg_wr && reg_idx == cwkd_pkg::REG_DISTINCT_TARGET) begin
			target_q <= pwdata[cwkd_pkg::DIST_W-1:0];
		end
	end

	cwkd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.value      (value),
		.last       (last),
		.item_valid (fe_valid),
		.item       (fe_item),
		.item_pop   (fe_pop)
	);

	cwkd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.target    (target_q),
		.fe_valid  (fe_valid),
		.fe_item   (fe_item),
		.fe_pop    (fe_pop),
		.res_space (res_space),
		.res_push  (res_push),
		.res_out   (res_out)
	);

	cwkd_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.res_in    (res_out),
		.res_space (res_space),
		.pop       (pop),
		.empty     (empty),
		.head      (res_head)
	);

	assign running_count = res_head.running_count;
	assign last_res      = res_head.last_res;
	assign overflow      = res_head.overflow;

endmodule

`default_nettype wire

### hw/rtl/cwkd_front.sv
// Front end: takes requests, marks those beyond the sequence length limit
// and queues them for the back end. Depends on cwkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cwkd_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [cwkd_pkg::VALUE_W-1:0]  value,
	input  wire logic                          last,
	output logic                               item_valid,
	output cwkd_pkg::front_item_t              item,
	input  wire logic                          item_pop
);

	cwkd_pkg::front_item_t             fq_q [cwkd_pkg::FQ_DEPTH];
	logic [cwkd_pkg::FQ_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [cwkd_pkg::FQ_CNT_W-1:0]     cnt_q;
	logic [cwkd_pkg::POS_W-1:0]        seq_cnt_q;
	logic                              accept;
	logic                              do_pop;
	logic                              skip;

	assign full       = (cnt_q == cwkd_pkg::FQ_CNT_W'(cwkd_pkg::FQ_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = fq_q[rd_ptr_q];
	assign accept     = push && !full;
	assign do_pop     = item_pop && item_valid;
	assign skip       = (seq_cnt_q == cwkd_pkg::POS_W'(cwkd_pkg::MAX_LEN));

	always_ff @(posedge clk) begin
		if (accept) begin
			fq_q[wr_ptr_q] <= '{value: value, last: last, skip: skip};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			cnt_q     <= '0;
			seq_cnt_q <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				if (last) begin
					seq_cnt_q <= '0;
				end else if (!skip) begin
					seq_cnt_q <= seq_cnt_q + 1'b1;
				end
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({accept, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/cwkd_resq.sv
// Two-entry result queue between the back end and the result ports.
// Depends on cwkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cwkd_resq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               res_push,
	input  wire cwkd_pkg::result_t  res_in,
	output logic                    res_space,
	input  wire logic               pop,
	output logic                    empty,
	output cwkd_pkg::result_t       head
);

	cwkd_pkg::result_t             rq_q [cwkd_pkg::RQ_DEPTH];
	logic [cwkd_pkg::RQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [cwkd_pkg::RQ_CNT_W-1:0] cnt_q;
	logic                          do_push, do_pop;

	assign res_space = (cnt_q != cwkd_pkg::RQ_CNT_W'(cwkd_pkg::RQ_DEPTH));
	assign empty     = (cnt_q == '0);
	assign head      = rq_q[rd_ptr_q];
	assign do_push   = res_push && res_space;
	assign do_pop    = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			rq_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/cwkd_back.sv
// Back end: sequencer over the per-value tally table and the history store,
// sliding the window and updating the running total. Depends on cwkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cwkd_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [cwkd_pkg::DIST_W-1:0]  target,
	input  wire logic                         fe_valid,
	input  wire cwkd_pkg::front_item_t        fe_item,
	output logic                              fe_pop,
	input  wire logic                         res_space,
	output logic                              res_push,
	output cwkd_pkg::result_t                 res_out
);

	cwkd_pkg::state_t state_q, state_d;

	// tally table: one write port, one registered read port, valid bit per entry
	logic [cwkd_pkg::TALLY_W-1:0]     tally_mem [cwkd_pkg::VALUE_COUNT];
	logic [cwkd_pkg::VALUE_COUNT-1:0] tally_vld_q;
	logic [cwkd_pkg::TALLY_W-1:0]     tally_rd_q;
	logic                             tally_rv_q;
	logic [cwkd_pkg::SLOT_W-1:0]      tally_raddr, tally_waddr;
	logic [cwkd_pkg::TALLY_W-1:0]     tally_wdata;
	logic                             tally_we, tally_clr;
	logic [cwkd_pkg::TALLY_W-1:0]     tv;

	// history store
	logic [cwkd_pkg::SLOT_W-1:0]      hist_mem [cwkd_pkg::MAX_LEN];
	logic [cwkd_pkg::SLOT_W-1:0]      hist_rd_q;
	logic [cwkd_pkg::HADDR_W-1:0]     hist_raddr;
	logic                             hist_we;

	logic [cwkd_pkg::POS_W-1:0]       write_pos_q, left_pos_q, right_q, repeat_q;
	logic [cwkd_pkg::POS_W-1:0]       left_inc;
	logic [cwkd_pkg::DIST_W-1:0]      distinct_q;
	logic [cwkd_pkg::TOTAL_W-1:0]     total_q, total_next;
	logic [cwkd_pkg::TOTAL_W:0]       total_sum;
	logic                             ovf_q, last_q, take_q;
	logic [cwkd_pkg::SLOT_W-1:0]      slot_q, s_q;
	logic [cwkd_pkg::SLOT_W-1:0]      fe_slot;
	logic                             start, more, hit;

	assign fe_slot  = fe_item.value[cwkd_pkg::SLOT_W-1:0];
	assign start    = fe_valid && res_space;
	assign tv       = tally_rv_q ? tally_rd_q : '0;
	assign left_inc = left_pos_q + 1'b1;
	assign more     = (left_inc <= right_q);

	assign hit       = take_q && (target != '0) && (distinct_q == target);
	assign total_sum = {1'b0, total_q} + (cwkd_pkg::TOTAL_W + 1)'(repeat_q) + 1'b1;
	always_comb begin
		if (!hit) begin
			total_next = total_q;
		end else if (total_sum > {1'b0, cwkd_pkg::TOTAL_MAX}) begin
			total_next = cwkd_pkg::TOTAL_MAX;
		end else begin
			total_next = total_sum[cwkd_pkg::TOTAL_W-1:0];
		end
	end

	assign res_out = '{running_count: total_next, last_res: last_q, overflow: ovf_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cwkd_pkg::ST_IDLE: begin
				if (start) begin
					state_d = fe_item.skip ? cwkd_pkg::ST_FIN : cwkd_pkg::ST_INC;
				end
			end
			cwkd_pkg::ST_INC:   state_d = cwkd_pkg::ST_HEAD;
			cwkd_pkg::ST_HEAD: begin
				state_d = (distinct_q > target) ? cwkd_pkg::ST_EVDEC : cwkd_pkg::ST_CHK;
			end
			cwkd_pkg::ST_EVDEC: state_d = more ? cwkd_pkg::ST_FETCH : cwkd_pkg::ST_FIN;
			cwkd_pkg::ST_FETCH: state_d = cwkd_pkg::ST_CHK;
			cwkd_pkg::ST_CHK: begin
				state_d = (tv > cwkd_pkg::TALLY_W'(1) && more) ? cwkd_pkg::ST_FETCH
				                                                : cwkd_pkg::ST_FIN;
			end
			cwkd_pkg::ST_FIN:   state_d = cwkd_pkg::ST_IDLE;
			default:            state_d = cwkd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		fe_pop      = 1'b0;
		res_push    = 1'b0;
		tally_we    = 1'b0;
		tally_clr   = 1'b0;
		tally_waddr = s_q;
		tally_wdata = tv - cwkd_pkg::TALLY_W'(1);
		tally_raddr = s_q;
		hist_we     = 1'b0;
		hist_raddr  = left_pos_q[cwkd_pkg::HADDR_W-1:0];
		unique case (state_q)
			cwkd_pkg::ST_IDLE: begin
				if (start) begin
					fe_pop = 1'b1;
					if (!fe_item.skip) begin
						hist_we     = 1'b1;
						tally_raddr = fe_slot;
					end
				end
			end
			cwkd_pkg::ST_INC: begin
				tally_we    = 1'b1;
				tally_waddr = slot_q;
				tally_wdata = tv + cwkd_pkg::TALLY_W'(1);
			end
			cwkd_pkg::ST_HEAD:  tally_raddr = hist_rd_q;
			cwkd_pkg::ST_EVDEC: begin
				tally_we    = 1'b1;
				tally_wdata = (tv != '0) ? tv - cwkd_pkg::TALLY_W'(1) : tv;
				hist_raddr  = left_inc[cwkd_pkg::HADDR_W-1:0];
			end
			cwkd_pkg::ST_FETCH: tally_raddr = hist_rd_q;
			cwkd_pkg::ST_CHK: begin
				tally_we   = (tv > cwkd_pkg::TALLY_W'(1));
				hist_raddr = left_inc[cwkd_pkg::HADDR_W-1:0];
			end
			cwkd_pkg::ST_FIN: begin
				res_push  = 1'b1;
				tally_clr = last_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tally_we) begin
			tally_mem[tally_waddr] <= tally_wdata;
		end
		tally_rd_q <= tally_mem[tally_raddr];
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[write_pos_q[cwkd_pkg::HADDR_W-1:0]] <= fe_slot;
		end
		hist_rd_q <= hist_mem[hist_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_vld_q <= '0;
			tally_rv_q  <= 1'b0;
		end else begin
			if (tally_clr) begin
				tally_vld_q <= '0;
			end else if (tally_we) begin
				tally_vld_q[tally_waddr] <= 1'b1;
			end
			tally_rv_q <= tally_vld_q[tally_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cwkd_pkg::ST_IDLE && start) begin
			slot_q <= fe_slot;
		end
		if (state_q == cwkd_pkg::ST_HEAD || state_q == cwkd_pkg::ST_FETCH) begin
			s_q <= hist_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cwkd_pkg::ST_IDLE;
			write_pos_q <= '0;
			left_pos_q  <= '0;
			right_q     <= '0;
			repeat_q    <= '0;
			distinct_q  <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			take_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				cwkd_pkg::ST_IDLE: begin
					if (start) begin
						last_q <= fe_item.last;
						take_q <= !fe_item.skip;
						if (fe_item.skip) begin
							ovf_q <= 1'b1;
						end else begin
							right_q     <= write_pos_q;
							write_pos_q <= write_pos_q + 1'b1;
						end
					end
				end
				cwkd_pkg::ST_INC: begin
					if (tv == '0) begin
						distinct_q <= distinct_q + 1'b1;
					end
				end
				cwkd_pkg::ST_EVDEC: begin
					distinct_q <= distinct_q - 1'b1;
					left_pos_q <= left_inc;
					repeat_q   <= '0;
				end
				cwkd_pkg::ST_CHK: begin
					if (tv > cwkd_pkg::TALLY_W'(1)) begin
						left_pos_q <= left_inc;
						repeat_q   <= repeat_q + 1'b1;
					end
				end
				cwkd_pkg::ST_FIN: begin
					total_q <= total_next;
					if (last_q) begin
						write_pos_q <= '0;
						left_pos_q  <= '0;
						repeat_q    <= '0;
						distinct_q  <= '0;
						total_q     <= '0;
						ovf_q       <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_left_behind_write: assert property (@(posedge clk) disable iff (!arst_n)
		left_pos_q <= write_pos_q)
		else $error("left position passed write position");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> res_space)
		else $error("result pushed into full queue");

	a_evict_over_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cwkd_pkg::ST_EVDEC) |-> (distinct_q > target))
		else $error("eviction without excess distinct values");

	a_distinct_bound: assert property (@(posedge clk) disable iff (!arst_n)
		distinct_q <= cwkd_pkg::DIST_W'(cwkd_pkg::VALUE_COUNT))
		else $error("distinct count out of range");

	a_pop_starts_item: assert property (@(posedge clk) disable iff (!arst_n)
		fe_pop |=> (state_q == cwkd_pkg::ST_INC || state_q == cwkd_pkg::ST_FIN))
		else $error("request taken without starting work");
`endif

endmodule

`default_nettype wire

### sim/count_windows_with_k_distinct_test.sv
`timescale 1ns / 1ps
// Self-checking bench for count_windows_with_k_distinct: a window-count predictor
// in a scoreboard class, queue-style request/result drivers and APB writes/reads.
// Depends on cwkd_pkg and the count_windows_with_k_distinct RTL.

class window_count_board;
	int unsigned tally [cwkd_pkg::VALUE_COUNT];
	logic [cwkd_pkg::SLOT_W-1:0] hist [cwkd_pkg::MAX_LEN];
	int unsigned wpos;
	int unsigned lpos;
	int unsigned distinct;
	int unsigned repeats;
	int unsigned total_acc;
	int unsigned target;
	bit overflowed;
	cwkd_pkg::result_t expected_q[$];
	int fail_count;

	function new();
		target = cwkd_pkg::DIST_TARGET_RESET;
		fail_count = 0;
		clear_seq();
	endfunction

	function void clear_seq();
		foreach (tally[i]) tally[i] = 0;
		wpos = 0;
		lpos = 0;
		distinct = 0;
		repeats = 0;
		total_acc = 0;
		overflowed = 0;
	endfunction

	function void set_target(int unsigned t);
		target = t;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	task report(string msg);
		fail_count++;
		$display("mismatch: %s", msg);
	endtask

	function void store(logic [cwkd_pkg::VALUE_W-1:0] v);
		int unsigned newest;
		logic [cwkd_pkg::SLOT_W-1:0] s;
		newest = wpos;
		hist[newest] = v;
		wpos = newest + 1;
		tally[v]++;
		if (tally[v] == 1)
			distinct++;
		// one distinct too many: drop the oldest, restart the repeat run
		if (distinct > target && lpos <= newest) begin
			s = hist[lpos];
			if (tally[s] > 0)
				tally[s]--;
			distinct--;
			lpos++;
			repeats = 0;
		end
		// strip leading entries that still occur later in the window
		while (lpos <= newest && tally[hist[lpos]] > 1) begin
			tally[hist[lpos]]--;
			repeats++;
			lpos++;
		end
		if (target != 0 && distinct == target) begin
			if (total_acc + repeats + 1 > int'(cwkd_pkg::TOTAL_MAX))
				total_acc = cwkd_pkg::TOTAL_MAX;
			else
				total_acc += repeats + 1;
		end
	endfunction

	function void note_request(logic [cwkd_pkg::VALUE_W-1:0] v, logic l);
		cwkd_pkg::result_t r;
		if (wpos >= cwkd_pkg::MAX_LEN)
			overflowed = 1;
		else
			store(v);
		r.running_count = total_acc[cwkd_pkg::TOTAL_W-1:0];
		r.last_res = l;
		r.overflow = overflowed;
		expected_q.push_back(r);
		if (l)
			clear_seq();
	endfunction

	task check_result(cwkd_pkg::result_t got);
		cwkd_pkg::result_t want;
		if (expected_q.size() == 0) begin
			report($sformatf("result with nothing expected: count %0d", got.running_count));
			return;
		end
		want = expected_q.pop_front();
		if (got.running_count !== want.running_count)
			report($sformatf("running_count %0d, want %0d", got.running_count,
				want.running_count));
		if (got.last_res !== want.last_res)
			report($sformatf("last_res %b, want %b", got.last_res, want.last_res));
		if (got.overflow !== want.overflow)
			report($sformatf("overflow %b, want %b", got.overflow, want.overflow));
	endtask
endclass

module count_windows_with_k_distinct_test;

	localparam int CLK_HALF = 10;
	localparam int STALL_LIMIT = 20000;
	localparam logic [cwkd_pkg::PADDR_W-1:0] TARGET_ADDR =
		cwkd_pkg::PADDR_W'(4 * cwkd_pkg::REG_DISTINCT_TARGET);

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	logic [cwkd_pkg::VALUE_W-1:0] value;
	logic last;
	logic empty;
	logic pop = 1'b0;
	logic [cwkd_pkg::TOTAL_W-1:0] running_count;
	logic last_res;
	logic overflow;
	logic psel;
	logic penable;
	logic pwrite;
	logic [cwkd_pkg::PADDR_W-1:0] paddr;
	logic [cwkd_pkg::PDATA_W-1:0] pwdata;
	logic [cwkd_pkg::PDATA_W-1:0] prdata;
	logic pready;

	window_count_board board = new();
	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	int quiet_cycles = 0;
	int sent;

	count_windows_with_k_distinct dut (.*);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk)
		pop <= ($urandom_range(0, 99) >= pop_stall_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				board.note_request(value, last);
			if (pop && !empty)
				board.check_result({running_count, last_res, overflow});
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[count_windows_with_k_distinct] ERROR");
				$finish;
			end
		end
	end

	task automatic send_request(logic [cwkd_pkg::VALUE_W-1:0] v, logic l);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		value <= v;
		last <= l;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// wait out every outstanding request, then let the back end settle
	task automatic drain();
		push <= 1'b0;
		do
			@(posedge clk);
		while (board.pending() != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic read_target(logic [cwkd_pkg::DIST_W-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= TARGET_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[cwkd_pkg::DIST_W-1:0] !== want)
			board.report($sformatf("distinct_target reads %0d, want %0d",
				prdata[cwkd_pkg::DIST_W-1:0], want));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_target(logic [cwkd_pkg::DIST_W-1:0] t);
		logic [cwkd_pkg::PDATA_W-1:0] d;
		drain();
		d = $urandom();
		d[cwkd_pkg::DIST_W-1:0] = t;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TARGET_ADDR;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.set_target(t);
		@(posedge clk);
		read_target(t);
	endtask

	// one whole sequence; counting mode walks base, base+1, ... for many distinct values
	task automatic send_run(int len, int alpha, logic [cwkd_pkg::VALUE_W-1:0] base,
		bit counting);
		logic [cwkd_pkg::VALUE_W-1:0] v;
		for (int i = 0; i < len; i++) begin
			if (counting)
				v = base + cwkd_pkg::VALUE_W'(i);
			else
				v = base + cwkd_pkg::VALUE_W'($urandom_range(0, alpha - 1));
			send_request(v, i == len - 1);
		end
		sent += len;
	endtask

	task automatic random_phase(logic [cwkd_pkg::DIST_W-1:0] t, int budget);
		int alpha;
		int pick;
		bit paused;
		set_target(t);
		sent = 0;
		paused = 0;
		while (sent < budget) begin
			if (!paused && sent >= budget / 2) begin
				drain();
				paused = 1;
			end
			pick = $urandom_range(0, 9);
			if (t == 0 || t > 8)
				alpha = $urandom_range(1, 8);
			else
				alpha = t + $urandom_range(0, 2);
			if (pick < 7)
				send_run($urandom_range(1, 30), alpha, cwkd_pkg::VALUE_W'($urandom()), 0);
			else if (pick < 9)
				send_run($urandom_range(1, 12), 256, cwkd_pkg::VALUE_W'($urandom()), 0);
			else
				send_run($urandom_range(1, 12), 1, cwkd_pkg::VALUE_W'($urandom()), 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		value = '0;
		last = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_target(cwkd_pkg::DIST_TARGET_RESET);

		// directed: value extremes, repeats, evictions, zero and top targets
		send_request(8'd0, 1'b0);
		send_request(8'd0, 1'b0);
		send_request(8'd255, 1'b0);
		send_request(8'd255, 1'b1);
		set_target(9'd2);
		send_request(8'd0, 1'b0);
		send_request(8'd255, 1'b0);
		send_request(8'd0, 1'b0);
		send_request(8'd128, 1'b0);
		send_request(8'd128, 1'b0);
		send_request(8'd7, 1'b1);
		set_target(9'd0);
		send_request(8'd5, 1'b0);
		send_request(8'd6, 1'b1);
		set_target(9'd256);
		send_request(8'd1, 1'b0);
		send_request(8'd2, 1'b0);
		send_request(8'd3, 1'b1);

		// full speed: one sequence past the length limit, one with every value
		set_target(9'd1);
		send_run(cwkd_pkg::MAX_LEN + 6, 2, cwkd_pkg::VALUE_W'($urandom()), 0);
		set_target(9'd256);
		send_run(256 + $urandom_range(2, 8), 1, cwkd_pkg::VALUE_W'($urandom()), 1);
		random_phase(cwkd_pkg::DIST_W'($urandom_range(1, 6)), 20);

		send_idle_pct = 87;
		pop_stall_pct = 0;
		random_phase(cwkd_pkg::DIST_W'($urandom_range(1, 6)), 20);
		random_phase(9'd0, 20);

		send_idle_pct = 0;
		pop_stall_pct = 87;
		random_phase(cwkd_pkg::DIST_W'($urandom_range(2, 8)), 20);
		random_phase(9'd511, 20);

		send_idle_pct = 11;
		pop_stall_pct = 11;
		random_phase(cwkd_pkg::DIST_W'($urandom_range(1, 4)), 20);
		random_phase(9'd257, 20);

		drain();
		if (board.fail_count == 0)
			$display("[count_windows_with_k_distinct] OK");
		else
			$display("[count_windows_with_k_distinct] ERROR");
		$finish;
	end
endmodule
